### rtl/pus_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pus_pkg
// Shared types for the priority unit scheduler.
// ----------------------------------------------------------------------------
package pus_pkg;

  localparam int unsigned BacklogWidth = 40;
  localparam int unsigned FieldWidth   = 16;
  localparam int unsigned CountWidth   = 5;

  typedef enum logic {
    KIND_ARRIVAL = 1'b0,
    KIND_TICK    = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_OUTPUT
  } state_e;

  typedef struct packed {
    kind_e                 kind;
    logic [FieldWidth-1:0] pri;
    logic [FieldWidth-1:0] work;
  } job_cmd_t;

  typedef struct packed {
    logic                    served_valid;
    logic [FieldWidth-1:0]   served_priority;
    logic [FieldWidth-1:0]   served_left;
    logic [BacklogWidth-1:0] weighted_backlog;
    logic                    dropped;
    logic [CountWidth-1:0]   pending_count;
  } result_t;

endpackage
`default_nettype wire

### rtl/pus_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pus_front
// Input stage and two-entry command queue; masks fields to their widths.
// ----------------------------------------------------------------------------
module pus_front #(
  parameter int unsigned PriorityWidth = 16,
  parameter int unsigned WorkWidth     = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              kind_i,
  input  wire logic [15:0]       job_priority_i,
  input  wire logic [15:0]       job_work_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output pus_pkg::job_cmd_t      cmd_o
);
  import pus_pkg::*;

  localparam int unsigned PW = (PriorityWidth < FieldWidth) ? PriorityWidth : FieldWidth;
  localparam int unsigned WW = (WorkWidth < FieldWidth) ? WorkWidth : FieldWidth;

  job_cmd_t   buf_q [2];
  logic [1:0] vld_q, vld_d;
  logic       wr_q, rd_q;
  job_cmd_t   in_cmd;
  logic       push, pop;

  always_comb begin
    in_cmd.kind = kind_e'(kind_i);
    in_cmd.pri  = job_priority_i & FieldWidth'((17'd1 << PW) - 17'd1);
    in_cmd.work = job_work_i & FieldWidth'((17'd1 << WW) - 17'd1);
  end

  assign in_ready_o  = !vld_q[wr_q];
  assign cmd_valid_o = vld_q[rd_q];
  assign cmd_o       = buf_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (push) vld_d[wr_q] = 1'b1;
    if (pop) vld_d[rd_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_cmd;
  end

endmodule
`default_nettype wire

### rtl/pus_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pus_back
// Slot store, best-job search, backlog update and result register.
// ----------------------------------------------------------------------------
module pus_back #(
  parameter int unsigned QueueDepth = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cmd_valid_i,
  output logic              cmd_ready_o,
  input  pus_pkg::job_cmd_t cmd_i,
  output logic              res_valid_o,
  input  wire logic         res_ready_i,
  output pus_pkg::result_t  res_o
);
  import pus_pkg::*;

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [FieldWidth-1:0]   pri_q [QueueDepth];
  logic [FieldWidth-1:0]   rem_q [QueueDepth];
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [BacklogWidth-1:0] bl_q, bl_d;
  state_e                  st_q, st_d;
  job_cmd_t                cmd_q;
  logic [IdxW-1:0]         best_q, best_d;
  logic [IdxW-1:0]         scan_q, scan_d;
  logic [2*FieldWidth-1:0] prod_q;
  result_t                 res_q, res_d;
  logic                    load, upd;
  logic [FieldWidth-1:0]   left;

  assign cmd_ready_o = (st_q == ST_IDLE);
  assign res_valid_o = (st_q == ST_OUTPUT);
  assign res_o       = res_q;
  assign load        = cmd_valid_i && cmd_ready_o;
  assign left        = rem_q[best_q] - FieldWidth'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      bl_q  <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      bl_q  <= bl_d;
    end
  end

  // scan walks slots one per cycle, keeping the running best
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    bl_d   = bl_q;
    best_d = best_q;
    scan_d = scan_q;
    res_d  = res_q;
    upd    = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        best_d = '0;
        scan_d = IdxW'(1);
        if (load) st_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (cmd_q.kind == KIND_TICK && CntW'(scan_q) < cnt_q && scan_q != '0) begin
          if (pri_q[scan_q] > pri_q[best_q] ||
              (pri_q[scan_q] == pri_q[best_q] && rem_q[scan_q] >= rem_q[best_q]))
            best_d = scan_q;
          scan_d = scan_q + IdxW'(1);
        end else begin
          st_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        res_d = '0;
        upd   = 1'b1;
        if (cmd_q.kind == KIND_ARRIVAL) begin
          if (cmd_q.work != '0) begin
            if (cnt_q == CntW'(QueueDepth)) begin
              res_d.dropped = 1'b1;
            end else begin
              cnt_d = cnt_q + CntW'(1);
              bl_d  = bl_q + BacklogWidth'(prod_q);
            end
          end
        end else if (cnt_q != '0) begin
          res_d.served_valid    = 1'b1;
          res_d.served_priority = pri_q[best_q];
          res_d.served_left     = left;
          bl_d                  = bl_q - BacklogWidth'(pri_q[best_q]);
          if (left == '0) cnt_d = cnt_q - CntW'(1);
        end
        res_d.weighted_backlog = bl_d;
        res_d.pending_count    = CountWidth'(cnt_d);
        st_d = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (res_ready_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) cmd_q <= cmd_i;
    prod_q <= cmd_q.pri * cmd_q.work;
    best_q <= best_d;
    scan_q <= scan_d;
    res_q  <= res_d;
  end

  // slot writes: append, decrement in place, or shift newer slots down
  for (genvar k = 0; k < QueueDepth; k++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pri_q[k] <= '0;
        rem_q[k] <= '0;
      end else if (upd) begin
        if (cmd_q.kind == KIND_ARRIVAL) begin
          if (cmd_q.work != '0 && cnt_q == CntW'(k)) begin
            pri_q[k] <= cmd_q.pri;
            rem_q[k] <= cmd_q.work;
          end
        end else if (cnt_q != '0) begin
          if (left != '0) begin
            if (best_q == IdxW'(k)) rem_q[k] <= left;
          end else if (CntW'(k) >= CntW'(best_q)) begin
            if (k + 1 < QueueDepth && CntW'(k + 1) < cnt_q) begin
              pri_q[k] <= pri_q[(k + 1) % QueueDepth];
              rem_q[k] <= rem_q[(k + 1) % QueueDepth];
            end else begin
              pri_q[k] <= '0;
              rem_q[k] <= '0;
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/priority_unit_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_unit_scheduler
// Preemptive priority scheduler with a weighted backlog.
// ----------------------------------------------------------------------------
// Each item gives one result. A front queue of two entries takes items while
// the back end works; the back end scans the slots one per cycle to find the
// job to serve on a tick; an arrival skips the scan and uses the registered
// multiply. The back end takes no new item until out_ready_i takes its result.
module priority_unit_scheduler #(
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned PRIORITY_WIDTH = 16,
  parameter int unsigned WORK_WIDTH     = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [15:0] job_priority_i,
  input  wire logic [15:0] job_work_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             served_valid_o,
  output logic [15:0]      served_priority_o,
  output logic [15:0]      served_left_o,
  output logic [39:0]      weighted_backlog_o,
  output logic             dropped_o,
  output logic [4:0]       pending_count_o
);
  import pus_pkg::*;

  job_cmd_t cmd;
  logic     cmd_valid, cmd_ready;
  result_t  res;

  pus_front #(.PriorityWidth(PRIORITY_WIDTH), .WorkWidth(WORK_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .job_priority_i, .job_work_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  pus_back #(.QueueDepth(QUEUE_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res)
  );

  assign served_valid_o     = res.served_valid;
  assign served_priority_o  = res.served_priority;
  assign served_left_o      = res.served_left;
  assign weighted_backlog_o = res.weighted_backlog;
  assign dropped_o          = res.dropped;
  assign pending_count_o    = res.pending_count;

endmodule
`default_nettype wire
